// ----- src/ihp_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Shared types, codes and constants of the IPv4 header parser.
// ----------------------------------------------------------------------------
package ihp_pkg;

  localparam int unsigned HdrBytes = 20;
  localparam logic [15:0] FragMask = 16'h3FFF;
  localparam logic [7:0]  OptRouterAlert = 8'h94;
  localparam logic [7:0]  OptEnd = 8'h00;
  localparam logic [7:0]  OptNop = 8'h01;
  localparam logic [3:0]  IpVersion4 = 4'd4;

  localparam logic [7:0] ProtoIcmp = 8'h01;
  localparam logic [7:0] ProtoIgmp = 8'h02;
  localparam logic [7:0] ProtoUdp  = 8'h11;
  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoGre  = 8'd47;
  localparam logic [7:0] ProtoEsp  = 8'd50;

  // Option flag bit positions.
  localparam int unsigned FlagTooLong    = 0;
  localparam int unsigned FlagBadLength  = 1;
  localparam int unsigned FlagAlertLen   = 2;
  localparam int unsigned FlagAlertValue = 3;
  localparam int unsigned FlagUnknown    = 4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FRAGMENT     = 3'd1,
    ST_BAD_VERSION  = 3'd2,
    ST_SHORT_HEADER = 3'd3,
    ST_SHORT_FRAME  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PC_ICMP    = 3'd0,
    PC_IGMP    = 3'd1,
    PC_UDP     = 3'd2,
    PC_TCP     = 3'd3,
    PC_GRE     = 3'd4,
    PC_ESP     = 3'd5,
    PC_UNKNOWN = 3'd6
  } proto_class_t;

  typedef enum logic [2:0] {
    PH_TAG  = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } opt_phase_t;

  // One frame byte as it leaves the input register.
  typedef struct packed {
    logic        last;
    logic [15:0] pos;
    logic [7:0]  data;
  } byte_step_t;

  function automatic proto_class_t classify(input logic [7:0] p);
    proto_class_t c;
    unique case (p)
      ProtoIcmp: c = PC_ICMP;
      ProtoIgmp: c = PC_IGMP;
      ProtoUdp:  c = PC_UDP;
      ProtoTcp:  c = PC_TCP;
      ProtoGre:  c = PC_GRE;
      ProtoEsp:  c = PC_ESP;
      default:   c = PC_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// ----- src/ipv4_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// IPv4 header parser
// Byte-serial IPv4 header extraction, checking and option walk.
// ----------------------------------------------------------------------------
// A frame's result reaches m_tdata from its last byte on s_tdata through the
// input register and then the result register.
// Throughput: one byte per cycle;
// a result held by m_tready stalls the input once the input register is full.
// Reset: synchronous rst clears the byte count, header bytes, option walker
// and both valid flags; no result is pending after reset.
module ipv4_header_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], protocol_class[5:3], protocol_number[13:6],
  // source_address[45:14], dest_address[77:46], header_bytes[83:78],
  // payload_bytes[99:84], option_flags[104:100], service_type[112:105],
  // time_to_live[120:113], identification[136:121], datagram_length[152:137],
  // zero fill [159:153]
  output logic [159:0] m_tdata
);

  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       advance;
  logic       consume;

  logic [15:0] pos;
  logic [ihp_pkg::HdrBytes-1:0][7:0] h;
  logic [15:0] frame_len;
  logic [4:0]  flags_final;
  logic [5:0]  hl;
  ihp_pkg::byte_step_t step;

  ihp_pkg::status_t status;
  logic [159:0]     result;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign consume  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign step = '{last: in_last, pos: pos, data: in_data};

  ihp_frame_track #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .en        (consume),
    .step      (step),
    .pos       (pos),
    .hdr_next  (h),
    .frame_len (frame_len)
  );

  assign hl = {h[0][3:0], 2'b00};

  ihp_opt_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .en          (consume),
    .step        (step),
    .hl          (hl),
    .flags_final (flags_final)
  );

  always_comb begin
    if (({h[6], h[7]} & ihp_pkg::FragMask) != 16'd0) begin
      status = ihp_pkg::ST_FRAGMENT;
    end else if (h[0][7:4] != ihp_pkg::IpVersion4) begin
      status = ihp_pkg::ST_BAD_VERSION;
    end else if (hl < 6'(ihp_pkg::HdrBytes)) begin
      status = ihp_pkg::ST_SHORT_HEADER;
    end else if ({10'd0, hl} > frame_len) begin
      status = ihp_pkg::ST_SHORT_FRAME;
    end else begin
      status = ihp_pkg::ST_OK;
    end

    result          = '0;
    result[2:0]     = status;
    result[5:3]     = ihp_pkg::classify(h[9]);
    result[13:6]    = h[9];
    if (status != ihp_pkg::ST_FRAGMENT) begin
      result[45:14] = {h[12], h[13], h[14], h[15]};
      result[77:46] = {h[16], h[17], h[18], h[19]};
    end
    result[83:78]   = hl;
    if (status == ihp_pkg::ST_OK) begin
      result[99:84]   = frame_len - {10'd0, hl};
      result[104:100] = flags_final;
    end
    result[112:105] = h[1];
    result[120:113] = h[8];
    result[136:121] = {h[4], h[5]};
    result[152:137] = {h[2], h[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      m_tdata <= result;
    end
  end

  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ihp_pkg::ST_OK |-> m_tdata[83:78] >= 6'd20)
    else $error("accepted frame with header under twenty bytes");

  a_frag_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ihp_pkg::ST_FRAGMENT |->
      m_tdata[77:14] == 64'd0)
    else $error("skipped fragment carries addresses");

  a_bad_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ihp_pkg::ST_OK |-> m_tdata[104:84] == 21'd0)
    else $error("failed frame carries payload length or option flags");

  a_result_needs_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(consume && in_last))
    else $error("result without a frame end");

endmodule

// ----- src/ihp_frame_track.sv -----
// ----------------------------------------------------------------------------
// IPv4 header parser frame tracker
// Counts bytes of the current frame and captures the first twenty bytes.
// ----------------------------------------------------------------------------
module ihp_frame_track #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  ihp_pkg::byte_step_t          step,
  output logic [15:0]                  pos,
  output logic [ihp_pkg::HdrBytes-1:0][7:0] hdr_next,
  output logic [15:0]                  frame_len
);

  localparam logic [15:0] MaxLen = 16'(MAX_FRAME_BYTES);

  logic [ihp_pkg::HdrBytes-1:0][7:0] store;

  // Header view including the byte in flight; bytes not yet seen read as zero.
  always_comb begin
    for (int i = 0; i < ihp_pkg::HdrBytes; i++) begin
      hdr_next[i] = (step.pos == 16'(i)) ? step.data : store[i];
    end
    frame_len = (step.pos >= MaxLen) ? MaxLen : step.pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      store <= '0;
    end else if (en) begin
      if (step.last) begin
        pos   <= '0;
        store <= '0;
      end else begin
        store <= hdr_next;
        if (pos < MaxLen) begin
          pos <= pos + 16'd1;
        end
      end
    end
  end

  a_pos_clears: assert property (@(posedge clk) disable iff (rst)
    en && step.last |=> pos == 16'd0)
    else $error("byte position not cleared after frame end");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= MaxLen)
    else $error("byte position beyond frame limit");

endmodule

// ----- src/ihp_opt_walk.sv -----
// ----------------------------------------------------------------------------
// IPv4 header parser option walker
// Walks the IP options byte by byte and collects option error flags.
// ----------------------------------------------------------------------------
module ihp_opt_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ihp_pkg::byte_step_t step,
  input  logic [5:0]          hl,
  output logic [4:0]          flags_final
);

  ihp_pkg::opt_phase_t phase, phase_next;
  logic [7:0]  remaining, remaining_next;
  logic [7:0]  tag, tag_next;
  logic [15:0] alert_value, alert_value_next;
  logic [1:0]  alert_pending, alert_pending_next;
  logic [4:0]  flags, flags_next;
  logic        stopped, stopped_next;
  logic        in_options;

  assign in_options = !stopped && (step.pos >= 16'(ihp_pkg::HdrBytes)) &&
                      (step.pos < {10'd0, hl});

  always_comb begin
    phase_next         = phase;
    remaining_next     = remaining;
    tag_next           = tag;
    alert_value_next   = alert_value;
    alert_pending_next = alert_pending;
    flags_next         = flags;
    stopped_next       = stopped;

    // Router alert value bytes are taken wherever they fall.
    if (alert_pending != 2'd0) begin
      alert_value_next   = {alert_value[7:0], step.data};
      alert_pending_next = alert_pending - 2'd1;
      if (alert_pending_next == 2'd0 && alert_value_next != 16'd0) begin
        flags_next[ihp_pkg::FlagAlertValue] = 1'b1;
      end
    end

    if (in_options) begin
      unique case (phase)
        ihp_pkg::PH_TAG: begin
          if (step.data == ihp_pkg::OptEnd) begin
            stopped_next = 1'b1;
          end else if (step.data != ihp_pkg::OptNop) begin
            if ({1'b0, step.pos} + 17'd1 >= {11'd0, hl}) begin
              flags_next[ihp_pkg::FlagTooLong] = 1'b1;
              stopped_next = 1'b1;
            end else begin
              tag_next   = step.data;
              phase_next = ihp_pkg::PH_LEN;
            end
          end
        end
        ihp_pkg::PH_LEN: begin
          if (step.data < 8'd2) begin
            flags_next[ihp_pkg::FlagBadLength] = 1'b1;
            stopped_next = 1'b1;
          end else if ({1'b0, step.pos} + {9'd0, step.data} > {11'd0, hl} + 17'd1) begin
            flags_next[ihp_pkg::FlagTooLong] = 1'b1;
            stopped_next = 1'b1;
          end else begin
            if (tag == ihp_pkg::OptRouterAlert) begin
              if (step.data != 8'd4) begin
                flags_next[ihp_pkg::FlagAlertLen] = 1'b1;
              end
              alert_value_next   = '0;
              alert_pending_next = 2'd2;
            end else begin
              flags_next[ihp_pkg::FlagUnknown] = 1'b1;
            end
            remaining_next = step.data - 8'd2;
            phase_next = (remaining_next == 8'd0) ? ihp_pkg::PH_TAG : ihp_pkg::PH_BODY;
          end
        end
        default: begin
          remaining_next = remaining - 8'd1;
          if (remaining_next == 8'd0) begin
            phase_next = ihp_pkg::PH_TAG;
          end
        end
      endcase
    end

    // At frame end, missing alert value bytes count as zero.
    flags_final = flags_next;
    if (alert_pending_next == 2'd1 && alert_value_next[7:0] != 8'd0) begin
      flags_final[ihp_pkg::FlagAlertValue] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ihp_pkg::PH_TAG;
      remaining     <= '0;
      tag           <= '0;
      alert_value   <= '0;
      alert_pending <= '0;
      flags         <= '0;
      stopped       <= 1'b0;
    end else if (en) begin
      if (step.last) begin
        phase         <= ihp_pkg::PH_TAG;
        remaining     <= '0;
        tag           <= '0;
        alert_value   <= '0;
        alert_pending <= '0;
        flags         <= '0;
        stopped       <= 1'b0;
      end else begin
        phase         <= phase_next;
        remaining     <= remaining_next;
        tag           <= tag_next;
        alert_value   <= alert_value_next;
        alert_pending <= alert_pending_next;
        flags         <= flags_next;
        stopped       <= stopped_next;
      end
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    alert_pending != 2'd3)
    else $error("router alert byte count out of range");

  a_walk_clears: assert property (@(posedge clk) disable iff (rst)
    en && step.last |=> flags == 5'd0 && !stopped && alert_pending == 2'd0)
    else $error("option walker not cleared after frame end");

endmodule
